@@ sv/fbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared constants, payload types and control types of the rectangle fill
// block.
// ----------------------------------------------------------------------------
package fbrf_pkg;

    localparam int SCREEN_SIDE = 128;
    localparam int STORE_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
    localparam int COORD_W     = $clog2(SCREEN_SIDE);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FIELD_W     = 8;
    localparam int SIZE_W      = FIELD_W + 1;
    localparam int PIXEL_W     = 16;

    localparam logic [SIZE_W-1:0] SIDE_S = SIZE_W'(SCREEN_SIDE);
    localparam logic [ADDR_W-1:0] SIDE_A = ADDR_W'(SCREEN_SIDE);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(STORE_DEPTH - 1);

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] rect_width;
        logic [FIELD_W-1:0] rect_height;
        logic [PIXEL_W-1:0] fill_colour;
        logic               on_top;
    } t_req;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_value;
        logic               rejected;
        logic               clipped_right;
        logic               clipped_bottom;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_FILL,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic in_ready;
        logic rd_issue;
        logic fill_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_valid;
        logic kind_read;
        logic skip;
        logic last_pixel;
        logic out_free;
    } t_stat;

endpackage

@@ sv/fbrf_if.sv @@
// ----------------------------------------------------------------------------
// fbrf_if
// Valid/ready channels for fill/read requests and their responses.
// ----------------------------------------------------------------------------
interface fbrf_req_if;
    logic             valid;
    logic             ready;
    fbrf_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fbrf_rsp_if;
    logic             valid;
    logic             ready;
    fbrf_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/framebuffer_rectangle_fill.sv @@
// ----------------------------------------------------------------------------
// framebuffer_rectangle_fill
// Square 16-bit frame store with clipped rectangle fill and pixel readback.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one item: a rectangle fill (origin, size, colour, on-top
//   flag) or a single pixel read. o_rsp returns exactly one item per request:
//   the pixel for a read, zero plus reject/clip flags for a fill.
//   After reset the block sweeps the whole store to zero, one pixel a cycle;
//   i_req.ready stays low until the sweep is done. One item is worked at a
//   time: an accepted item passes a decode state, then a read issues its
//   pixel read and loads the response register, while a fill sweeps its
//   covered pixels after clipping (up to 16384), one per cycle, set by the
//   single read-modify-write port of the frame store, and drains its last
//   write before the response; empty or rejected fills skip the sweep.
//   The response sits in an output register: if o_rsp is stalled the next
//   item is still accepted and worked, and only its own response waits for
//   the register to free up.
// ----------------------------------------------------------------------------
module framebuffer_rectangle_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbrf_req_if.sink    i_req,
    fbrf_rsp_if.source  o_rsp
);

    fbrf_pkg::t_cmd  cmd;
    fbrf_pkg::t_stat stat;

    fbrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fbrf_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

@@ sv/fbrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbrf_ctrl
// Sequencer: clearing pass, item decode, pixel read, fill sweep, response.
// ----------------------------------------------------------------------------
module fbrf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fbrf_pkg::t_stat i_stat,
    output fbrf_pkg::t_cmd  o_cmd
);

    fbrf_pkg::t_state r_state;
    fbrf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbrf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbrf_pkg::ST_CLEAR: begin
                if (i_stat.clr_done) n_state = fbrf_pkg::ST_IDLE;
            end
            fbrf_pkg::ST_IDLE: begin
                if (i_stat.in_valid) n_state = fbrf_pkg::ST_DECIDE;
            end
            fbrf_pkg::ST_DECIDE: begin
                if (i_stat.kind_read) begin
                    n_state = fbrf_pkg::ST_READ;
                end else if (i_stat.skip) begin
                    n_state = fbrf_pkg::ST_FINISH;
                end else begin
                    n_state = fbrf_pkg::ST_FILL;
                end
            end
            fbrf_pkg::ST_READ: begin
                n_state = fbrf_pkg::ST_FINISH;
            end
            fbrf_pkg::ST_FILL: begin
                if (i_stat.last_pixel) n_state = fbrf_pkg::ST_DRAIN;
            end
            fbrf_pkg::ST_DRAIN: begin
                // last write of the sweep lands here
                n_state = fbrf_pkg::ST_FINISH;
            end
            fbrf_pkg::ST_FINISH: begin
                if (i_stat.out_free) n_state = fbrf_pkg::ST_IDLE;
            end
            default: n_state = fbrf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.clear     = (r_state == fbrf_pkg::ST_CLEAR);
        o_cmd.in_ready  = (r_state == fbrf_pkg::ST_IDLE);
        o_cmd.rd_issue  = (r_state == fbrf_pkg::ST_READ);
        o_cmd.fill_step = (r_state == fbrf_pkg::ST_FILL);
        o_cmd.finish    = (r_state == fbrf_pkg::ST_FINISH) && i_stat.out_free;
    end

    a_fill_only_drawable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbrf_pkg::ST_FILL) |-> (!i_stat.skip && !i_stat.kind_read))
        else $error("fill sweep running on a read or empty item");

    a_finish_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("response loaded while output register busy");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbrf_pkg::ST_CLEAR) |=>
            (r_state == fbrf_pkg::ST_CLEAR || r_state == fbrf_pkg::ST_IDLE))
        else $error("left clearing pass into work");

endmodule

@@ sv/fbrf_datapath.sv @@
// ----------------------------------------------------------------------------
// fbrf_datapath
// Frame store, clip decode, fill address counters with read-modify-write
// pipeline, and the response register.
// ----------------------------------------------------------------------------
module fbrf_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fbrf_req_if.sink        i_req,
    fbrf_rsp_if.source      o_rsp,
    input  fbrf_pkg::t_cmd  i_cmd,
    output fbrf_pkg::t_stat o_stat
);

    logic [fbrf_pkg::PIXEL_W-1:0] r_frame [fbrf_pkg::STORE_DEPTH];

    logic [fbrf_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                         r_kind;
    logic                         r_top;
    logic [fbrf_pkg::PIXEL_W-1:0] r_colour;
    logic                         r_rd_oob;
    logic                         r_skip;
    logic                         r_rejected;
    logic                         r_clip_r;
    logic                         r_clip_b;
    logic [fbrf_pkg::COORD_W-1:0] r_col;
    logic [fbrf_pkg::COORD_W-1:0] r_col_first;
    logic [fbrf_pkg::COORD_W-1:0] r_col_last;
    logic [fbrf_pkg::COORD_W-1:0] r_row;
    logic [fbrf_pkg::COORD_W-1:0] r_row_last;
    logic [fbrf_pkg::ADDR_W-1:0]  r_row_base;
    logic                         r_p_valid;
    logic [fbrf_pkg::ADDR_W-1:0]  r_p_addr;
    logic [fbrf_pkg::PIXEL_W-1:0] r_rd_data;
    logic                         r_out_valid;
    fbrf_pkg::t_rsp               r_out;

    logic                         load;
    logic [fbrf_pkg::SIZE_W-1:0]  px9, py9, w9, h9, wc, hc, x_last, y_last;
    logic                         off_x, off_y, clip_x, clip_y, skip, rd_oob;
    logic [fbrf_pkg::ADDR_W-1:0]  cur_addr;
    logic                         mem_we;
    logic [fbrf_pkg::ADDR_W-1:0]  mem_wa;
    logic [fbrf_pkg::PIXEL_W-1:0] mem_wd;
    logic                         mem_re;
    logic                         row_end;
    fbrf_pkg::t_rsp               n_out;

    assign load = i_cmd.in_ready && i_req.valid;
    assign i_req.ready = i_cmd.in_ready;

    // clip decode on the incoming item
    always_comb begin
        px9    = {1'b0, i_req.data.pos_x};
        py9    = {1'b0, i_req.data.pos_y};
        w9     = {1'b0, i_req.data.rect_width};
        h9     = {1'b0, i_req.data.rect_height};
        off_x  = px9 > fbrf_pkg::SIDE_S;
        off_y  = py9 > fbrf_pkg::SIDE_S;
        clip_x = (px9 + w9) > fbrf_pkg::SIDE_S;
        clip_y = (py9 + h9) > fbrf_pkg::SIDE_S;
        wc     = clip_x ? (fbrf_pkg::SIDE_S - px9) : w9;
        hc     = clip_y ? (fbrf_pkg::SIDE_S - py9) : h9;
        x_last = px9 + wc - fbrf_pkg::SIZE_W'(1);
        y_last = py9 + hc - fbrf_pkg::SIZE_W'(1);
        skip   = off_x || off_y || (wc == '0) || (hc == '0);
        rd_oob = (px9 >= fbrf_pkg::SIDE_S) || (py9 >= fbrf_pkg::SIDE_S);
    end

    assign cur_addr = r_row_base + fbrf_pkg::ADDR_W'(r_col);
    assign row_end  = (r_col == r_col_last);
    assign mem_re   = i_cmd.rd_issue || i_cmd.fill_step;

    always_comb begin
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            // underlay mode writes only pixels that still hold zero
            mem_we = r_p_valid && (r_top || (r_rd_data == '0));
            mem_wa = r_p_addr;
            mem_wd = r_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_frame[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= r_frame[cur_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + fbrf_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.fill_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step) r_p_addr <= cur_addr;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind      <= i_req.data.kind;
            r_top       <= i_req.data.on_top;
            r_colour    <= i_req.data.fill_colour;
            r_rd_oob    <= rd_oob;
            r_skip      <= skip;
            r_rejected  <= (i_req.data.kind == fbrf_pkg::KIND_FILL) && (off_x || off_y);
            r_clip_r    <= (i_req.data.kind == fbrf_pkg::KIND_FILL) &&
                           ((off_x || off_y) ? off_x : clip_x);
            r_clip_b    <= (i_req.data.kind == fbrf_pkg::KIND_FILL) &&
                           ((off_x || off_y) ? off_y : clip_y);
            r_col       <= i_req.data.pos_x[fbrf_pkg::COORD_W-1:0];
            r_col_first <= i_req.data.pos_x[fbrf_pkg::COORD_W-1:0];
            r_col_last  <= x_last[fbrf_pkg::COORD_W-1:0];
            r_row       <= i_req.data.pos_y[fbrf_pkg::COORD_W-1:0];
            r_row_last  <= y_last[fbrf_pkg::COORD_W-1:0];
            r_row_base  <= fbrf_pkg::ADDR_W'(i_req.data.pos_y) * fbrf_pkg::SIDE_A;
        end else if (i_cmd.fill_step) begin
            if (row_end) begin
                r_col      <= r_col_first;
                r_row      <= r_row + fbrf_pkg::COORD_W'(1);
                r_row_base <= r_row_base + fbrf_pkg::SIDE_A;
            end else begin
                r_col <= r_col + fbrf_pkg::COORD_W'(1);
            end
        end
    end

    always_comb begin
        n_out.pixel_value    = ((r_kind == fbrf_pkg::KIND_READ) && !r_rd_oob) ?
                               r_rd_data : '0;
        n_out.rejected       = r_rejected;
        n_out.clipped_right  = r_clip_r;
        n_out.clipped_bottom = r_clip_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) r_out <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        o_stat.clr_done   = (r_clr_addr == fbrf_pkg::LAST_A);
        o_stat.in_valid   = i_req.valid;
        o_stat.kind_read  = (r_kind == fbrf_pkg::KIND_READ);
        o_stat.skip       = r_skip;
        o_stat.last_pixel = row_end && (r_row == r_row_last);
        o_stat.out_free   = !r_out_valid || o_rsp.ready;
    end

    a_fill_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> ((r_kind == fbrf_pkg::KIND_FILL) && !r_skip))
        else $error("pixel write pending for an item that draws nothing");

    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> (!r_p_valid && !i_req.ready))
        else $error("fill write or accept during clearing pass");

    a_sweep_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> ((r_col <= r_col_last) && (r_row <= r_row_last)))
        else $error("fill sweep ran past clipped rectangle");

endmodule
